// ===== hw/rtl/software_timer_scheduler_unit_assert.svh =====
// Assertion macros used by the timer scheduler RTL
`ifndef SOFTWARE_TIMER_SCHEDULER_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define STSU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stsu assertion failed");

// next-cycle implication
`define STSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stsu assertion failed");

`endif

// ===== hw/rtl/stsu_pkg.sv =====
// ---------------------------------------------------------------------------
// stsu_pkg
// Types and constants of the software timer scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stsu_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int CNT_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int TIME_W      = 48;

   localparam logic [1:0]  KIND_ADD     = 2'd0;
   localparam logic [1:0]  KIND_STOP    = 2'd1;
   localparam logic [1:0]  KIND_SERVICE = 2'd2;

   localparam logic [31:0] WAIT_CLAMP = 32'h7FFF_FFFF;
   localparam logic [31:0] WAIT_NONE  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] now_ms;
      logic [31:0] delay_ms;
      logic [31:0] period_ms;
      logic [31:0] target_id;
   } req_type;

   typedef struct packed {
      logic [31:0]        result_id;
      logic               fired;
      logic               found;
      logic signed [31:0] wait_ms;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [47:0] deadline;
      logic [31:0] period;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PREV,
      OP_NEXT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINAL
   } state_type;

   function automatic logic [47:0] sat_add(input logic [47:0] t, input logic [31:0] d);
      logic [48:0] s;
      s = {1'b0, t} + {17'd0, d};
      return s[48] ? {TIME_W{1'b1}} : s[47:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stsu_cell.sv =====
// ---------------------------------------------------------------------------
// stsu_cell
// One timer slot of the chain; loads from either neighbour or holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stsu_cell import stsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cell_op_type op,
   input  wire entry_type   prev_entry,
   input  wire entry_type   next_entry,
   input  wire logic        chain_in,
   output entry_type        entry_q,
   output logic             chain_out
);

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (op)
         OP_PREV: begin
            data_in  = prev_entry;
            valid_in = prev_entry.valid;
         end
         OP_NEXT: begin
            data_in  = next_entry;
            valid_in = next_entry.valid;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      entry_q       = data_ff;
      entry_q.valid = valid_ff;
   end

   // high while every slot up to and including this one is taken
   assign chain_out = chain_in & valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/software_timer_scheduler_unit.sv =====
// Add: result in the cycle after the beat; back-to-back adds allowed.
// Stop/service: the chain rotates once through all TIMER_SLOTS cells, one per
// cycle, then the final result; busy through the rotation and the final state,
// so no new item is taken until the final result is out.
// Fired results appear at most one per cycle during the rotation; no stall possible.
// Synchronous reset empties every slot and zeroes the id counter.
// ---------------------------------------------------------------------------
// software_timer_scheduler_unit
// Timer table held in a rotating chain of slot cells, newest at the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "software_timer_scheduler_unit_assert.svh"
module software_timer_scheduler_unit import stsu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        kind_ff, kind_in;
   logic [47:0]       now_ff, now_in;
   logic [31:0]       target_ff, target_in;
   logic              hit_ff, hit_in;
   logic              any_ff, any_in;
   logic [47:0]       best_ff, best_in;
   logic [31:0]       id_ctr_ff, id_ctr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   entry_type         cell_q [TIMER_SLOTS];
   cell_op_type       cell_op [TIMER_SLOTS];
   logic              chain [TIMER_SLOTS+1];
   entry_type         new_entry, head_upd;
   logic [31:0]       next_id;
   logic              accept, full, expired;
   logic [47:0]       diff;

   assign chain[0] = 1'b1;
   assign full     = chain[TIMER_SLOTS];
   assign accept   = start && (state_ff == ST_IDLE);

   genvar gi;
   generate
      for (gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
         entry_type pv, nx;
         if (gi == 0) begin : g_head
            assign pv = new_entry;
         end else begin : g_body
            assign pv = cell_q[gi-1];
         end
         if (gi == TIMER_SLOTS-1) begin : g_tail
            assign nx = head_upd;
         end else begin : g_mid
            assign nx = cell_q[gi+1];
         end
         stsu_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (cell_op[gi]),
            .prev_entry (pv),
            .next_entry (nx),
            .chain_in   (chain[gi]),
            .entry_q    (cell_q[gi]),
            .chain_out  (chain[gi+1])
         );
      end
   endgenerate

   assign next_id = (id_ctr_ff == 32'hFFFF_FFFF) ? 32'd1 : id_ctr_ff + 32'd1;

   always_comb begin
      new_entry.valid    = 1'b1;
      new_entry.id       = next_id;
      new_entry.deadline = sat_add(req_data.now_ms, req_data.delay_ms);
      new_entry.period   = req_data.period_ms;
   end

   // head slot as it re-enters at the tail
   assign expired = cell_q[0].valid && (now_ff >= cell_q[0].deadline);
   always_comb begin
      head_upd = cell_q[0];
      if (kind_ff == KIND_STOP) begin
         if (!hit_ff && cell_q[0].valid && (cell_q[0].id == target_ff)) begin
            head_upd.valid = 1'b0;
         end
      end else if (expired) begin
         if (cell_q[0].period != 32'd0) begin
            head_upd.deadline = sat_add(now_ff, cell_q[0].period);
         end else begin
            head_upd.valid = 1'b0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && ((req_data.kind == KIND_STOP) || (req_data.kind == KIND_SERVICE))) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (count_ff == CNT_W'(TIMER_SLOTS-1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign diff = best_ff - now_ff;

   // outputs and datapath
   always_comb begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         cell_op[i] = OP_HOLD;
      end
      count_in     = count_ff;
      kind_in      = kind_ff;
      now_in       = now_ff;
      target_in    = target_ff;
      hit_in       = hit_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      id_ctr_in    = id_ctr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            count_in  = '0;
            hit_in    = 1'b0;
            any_in    = 1'b0;
            kind_in   = req_data.kind;
            now_in    = req_data.now_ms;
            target_in = req_data.target_id;
            if (accept && (req_data.kind == KIND_ADD)) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (!full) begin
                  rsp_in.result_id = next_id;
                  id_ctr_in        = next_id;
                  for (int i = 0; i < TIMER_SLOTS; i++) begin
                     if (chain[i]) begin
                        cell_op[i] = OP_PREV;
                     end
                  end
               end
            end
         end
         ST_WALK: begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
               cell_op[i] = OP_NEXT;
            end
            count_in = count_ff + CNT_W'(1);
            if (kind_ff == KIND_STOP) begin
               if (cell_q[0].valid && !head_upd.valid) begin
                  hit_in = 1'b1;
               end
            end else begin
               if (expired) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.result_id = cell_q[0].id;
                  rsp_in.fired     = 1'b1;
               end
               if (head_upd.valid && (!any_ff || (head_upd.deadline < best_ff))) begin
                  any_in  = 1'b1;
                  best_in = head_upd.deadline;
               end
            end
         end
         ST_FINAL: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (kind_ff == KIND_STOP) begin
               rsp_in.found = hit_ff;
            end else if (!any_ff) begin
               rsp_in.wait_ms = WAIT_NONE;
            end else if (best_ff > now_ff) begin
               rsp_in.wait_ms = (diff > {16'd0, WAIT_CLAMP}) ? WAIT_CLAMP : diff[31:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      kind_ff   <= kind_in;
      now_ff    <= now_in;
      target_ff <= target_in;
      hit_ff    <= hit_in;
      any_ff    <= any_in;
      best_ff   <= best_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         id_ctr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `STSU_ASSERT_NOW(a_fired_not_last, clock, reset, rsp_valid_ff && rsp_ff.fired, !rsp_ff.last)
   `STSU_ASSERT_NOW(a_plain_is_last, clock, reset, rsp_valid_ff && !rsp_ff.fired, rsp_ff.last)
   `STSU_ASSERT_NEXT(a_final_beat, clock, reset, state_ff == ST_FINAL, rsp_valid_ff && rsp_ff.last)

endmodule
`default_nettype wire

// ===== sim/software_timer_scheduler_unit_checker.sv =====
// ---------------------------------------------------------------------------
// software_timer_scheduler_unit_checker
// Watches request and response beats, predicts the timer table and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module software_timer_scheduler_unit_checker import stsu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   logic        tm_valid [TIMER_SLOTS];
   logic [31:0] tm_id    [TIMER_SLOTS];
   logic [47:0] tm_due   [TIMER_SLOTS];
   logic [31:0] tm_period[TIMER_SLOTS];
   int          tm_rank  [TIMER_SLOTS];
   logic [31:0] id_count;
   rsp_type     due_rsps[$];

   assign pending_count = due_rsps.size();

   function automatic logic [47:0] time_plus(logic [47:0] t, logic [31:0] d);
      logic [48:0] s;
      s = {1'b0, t} + {17'd0, d};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

   function automatic rsp_type make_rsp(logic [31:0] id, logic f, logic fd,
                                        logic [31:0] w, logic l);
      rsp_type r;
      r.result_id = id; r.fired = f; r.found = fd; r.wait_ms = w; r.last = l;
      return r;
   endfunction

   task automatic retire_timer(int s);
      int r;
      r = tm_rank[s];
      tm_valid[s] = 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++)
         if (tm_valid[i] && tm_rank[i] > r) tm_rank[i]--;
   endtask

   // slots in age order, newest first
   task automatic newest_first(output int ord[TIMER_SLOTS], output int n);
      n = 0;
      for (int i = 0; i < TIMER_SLOTS; i++) if (tm_valid[i]) n++;
      for (int i = 0; i < TIMER_SLOTS; i++)
         if (tm_valid[i] && tm_rank[i] < n) ord[tm_rank[i]] = i;
   endtask

   task automatic predict_beat(req_type q);
      int          ord[TIMER_SLOTS];
      int          n, s;
      logic        hit, any;
      logic [47:0] best;
      logic [47:0] diff;
      logic [31:0] id, w;
      case (q.kind)
         KIND_ADD: begin
            s = -1;
            for (int i = 0; i < TIMER_SLOTS; i++)
               if (!tm_valid[i] && s < 0) s = i;
            if (s < 0) begin
               due_rsps.push_back(make_rsp(32'd0, 1'b0, 1'b0, 32'd0, 1'b1));
            end else begin
               id = id_count + 32'd1;
               if (id == 32'd0) id = 32'd1;
               id_count = id;
               for (int i = 0; i < TIMER_SLOTS; i++) if (tm_valid[i]) tm_rank[i]++;
               tm_valid[s] = 1'b1; tm_id[s] = id; tm_rank[s] = 0;
               tm_due[s] = time_plus(q.now_ms, q.delay_ms);
               tm_period[s] = q.period_ms;
               due_rsps.push_back(make_rsp(id, 1'b0, 1'b0, 32'd0, 1'b1));
            end
         end
         KIND_STOP: begin
            hit = 1'b0;
            newest_first(ord, n);
            for (int i = 0; i < n; i++)
               if (!hit && tm_id[ord[i]] == q.target_id) begin
                  retire_timer(ord[i]);
                  hit = 1'b1;
               end
            due_rsps.push_back(make_rsp(32'd0, 1'b0, hit, 32'd0, 1'b1));
         end
         KIND_SERVICE: begin
            newest_first(ord, n);
            for (int i = 0; i < n; i++) begin
               s = ord[i];
               if (q.now_ms >= tm_due[s]) begin
                  due_rsps.push_back(make_rsp(tm_id[s], 1'b1, 1'b0, 32'd0, 1'b0));
                  if (tm_period[s] != 32'd0) tm_due[s] = time_plus(q.now_ms, tm_period[s]);
                  else retire_timer(s);
               end
            end
            any = 1'b0; best = '0;
            for (int i = 0; i < TIMER_SLOTS; i++)
               if (tm_valid[i] && (!any || tm_due[i] < best)) begin
                  best = tm_due[i]; any = 1'b1;
               end
            if (!any) w = WAIT_NONE;
            else if (best <= q.now_ms) w = 32'd0;
            else begin
               diff = best - q.now_ms;
               w = (diff > 48'(WAIT_CLAMP)) ? WAIT_CLAMP : diff[31:0];
            end
            due_rsps.push_back(make_rsp(32'd0, 1'b0, 1'b0, w, 1'b1));
         end
         default: ;   // kind 3 is ignored
      endcase
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         for (int i = 0; i < TIMER_SLOTS; i++) tm_valid[i] = 1'b0;
         id_count = 32'd0;
         fail_count = 0;
         due_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (due_rsps.size() == 0) begin
               $display("%0t: response beat with nothing expected", $realtime);
               fail_count++;
            end else begin
               w = due_rsps.pop_front();
               if (rsp_data.result_id !== w.result_id)
                  report("result_id", rsp_data.result_id, w.result_id);
               if (rsp_data.fired !== w.fired)
                  report("fired", 32'(rsp_data.fired), 32'(w.fired));
               if (rsp_data.found !== w.found)
                  report("found", 32'(rsp_data.found), 32'(w.found));
               if (rsp_data.wait_ms !== w.wait_ms) report("wait_ms", rsp_data.wait_ms, w.wait_ms);
               if (rsp_data.last !== w.last)
                  report("last", 32'(rsp_data.last), 32'(w.last));
            end
         end
         if (start && !busy) predict_beat(req_data);
      end
   end

endmodule
`default_nettype wire

// ===== sim/software_timer_scheduler_unit_tb.sv =====
// ---------------------------------------------------------------------------
// software_timer_scheduler_unit_tb
// Directed then random add/stop/service and unused-kind beats with random gaps; verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module software_timer_scheduler_unit_tb import stsu_pkg::*;;

   logic    clock, reset, start, busy, rsp_valid;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   logic [47:0] clk_ms;
   logic [31:0] last_id;

   software_timer_scheduler_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   software_timer_scheduler_unit_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // drive one beat and hold start until accepted; start drops only for a gap
   task automatic send_beat(logic [1:0] k, logic [47:0] now, logic [31:0] dly,
                            logic [31:0] rpt, logic [31:0] tgt);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{kind: k, now_ms: now, delay_ms: dly, period_ms: rpt, target_id: tgt};
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] rand_delay();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 200);
      endcase
   endfunction

   initial begin
      logic [1:0] k;
      logic [31:0] tgt;
      int sel;
      reset = 1'b1; start = 1'b0; req_data = '0; clk_ms = 48'd1000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty service, fill past full, stops, expiries, extremes
      send_beat(KIND_SERVICE, 48'd0, 0, 0, 0);
      send_beat(KIND_STOP, 48'd0, 0, 0, 32'hFFFF_FFFF);
      for (int i = 0; i < 17; i++)
         send_beat(KIND_ADD, 48'hFFFF_FFFF_FF00 * (i == 0), (i == 1) ? 32'hFFFF_FFFF : i,
                   (i % 2) ? 32'hFFFF_FFFF : 0, 0);
      send_beat(KIND_STOP, 48'd0, 0, 0, 32'd3);
      send_beat(KIND_STOP, 48'd0, 0, 0, 32'd3);
      send_beat(2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(KIND_SERVICE, 48'd10, 0, 0, 0);
      send_beat(KIND_SERVICE, 48'hFFFF_FFFF_FFFF, 0, 0, 0);

      for (int n = 0; n < 500; n++) begin
         sel = $urandom_range(0, 9);
         clk_ms = clk_ms + $urandom_range(0, 60);
         if ($urandom_range(0, 40) == 0) clk_ms = 48'({$urandom, $urandom});
         k = (sel < 4) ? KIND_ADD : (sel < 6) ? KIND_STOP : (sel < 9) ? KIND_SERVICE : 2'd3;
         tgt = ($urandom_range(0, 3) == 0) ? $urandom : i_checker.id_count - $urandom_range(0, 20);
         send_beat(k, clk_ms, rand_delay(), ($urandom_range(0, 1)) ? 0 : rand_delay(), tgt);
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/stsu_pkg.sv
hw/rtl/stsu_cell.sv
hw/rtl/software_timer_scheduler_unit.sv
sim/software_timer_scheduler_unit_checker.sv
sim/software_timer_scheduler_unit_tb.sv
